// File: design/qsz_pkg.sv
`default_nettype none
package qsz_pkg;

  localparam int FRAME_WIDTH_DEF  = 800;
  localparam int FRAME_HEIGHT_DEF = 600;

  localparam int                 CRD_W       = 18;
  localparam int                 MUL_W       = 19;
  localparam int                 PROD_W      = 2 * MUL_W;
  localparam int                 DEN_W       = 20;
  localparam int                 ENT_W       = 19;
  localparam logic signed [15:0] DEPTH_EMPTY = 16'sh8000;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_RAST  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDREQ,
    ST_RDWAIT,
    ST_EDGE,
    ST_MUL,
    ST_DSTART,
    ST_DWAIT,
    ST_HIT,
    ST_ROWEND,
    ST_SPAN,
    ST_PADDR,
    ST_PRD,
    ST_PWR
  } state_t;

  // divide by 16, rounding toward zero
  function automatic crd_t trunc16(input crd_t v);
    crd_t m;
    m = v[CRD_W-1] ? -v : v;
    m = m >>> 4;
    return v[CRD_W-1] ? -m : m;
  endfunction

endpackage
`default_nettype wire

// File: design/qsz_div.sv
`default_nettype none
module qsz_div #(
  parameter int NW = qsz_pkg::PROD_W,
  parameter int DW = qsz_pkg::DEN_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [NW-1:0] num,
  input  wire logic signed [DW-1:0] den,
  output logic                      busy,
  output logic                      done,
  output logic signed [NW-1:0]      quo
);

  localparam int CW = $clog2(NW + 1);

  logic          run_r, done_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] dvd_r;
  logic [DW-1:0] rem_r, dvs_r;
  logic [DW:0]   sh, diff;
  logic          ge;

  always_comb begin
    sh   = {rem_r, dvd_r[NW-1]};
    diff = sh - {1'b0, dvs_r};
    ge   = (sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      dvd_r  <= num[NW-1] ? NW'(-num) : NW'(num);
      dvs_r  <= den[DW-1] ? DW'(-den) : DW'(den);
      rem_r  <= '0;
      neg_r  <= num[NW-1] ^ den[DW-1];
    end else if (run_r) begin
      dvd_r <= {dvd_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : sh[DW-1:0];
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(NW - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign busy = run_r;
  assign done = done_r;
  assign quo  = neg_r ? -$signed(dvd_r) : $signed(dvd_r);

endmodule
`default_nettype wire

// File: design/qsz_fbuf.sv
`default_nettype none
module qsz_fbuf #(
  parameter int DEPTH = qsz_pkg::FRAME_WIDTH_DEF * qsz_pkg::FRAME_HEIGHT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [qsz_pkg::ENT_W-1:0] wdata,
  input  wire logic [AW-1:0]            raddr,
  output logic [qsz_pkg::ENT_W-1:0]     rdata
);

  logic [qsz_pkg::ENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/quad_scanline_zbuffer_rasterizer.sv
// channel | ports                                              | dir
// in      | in_valid/in_ready, in_op, in_corner, in_vert_x/y/z, | request in
//         | in_face_id, in_read_col, in_read_row               |
// out     | out_valid/out_ready, out_pixel_depth, out_pixel_face| result out
// Pixel read: ST_RDREQ then ST_RDWAIT; the result register frees the input at once.
// Clear: all FRAME_WIDTH*FRAME_HEIGHT entries, one buffer entry a cycle; the same sweep runs
// after reset, with in_ready low.
// Rasterize: per row a step per edge plus a row-end step; a crossing edge adds two serial
// divisions; each span pixel takes a division (skipped when the span depth is flat) plus a
// read-modify-write (ST_PADDR, ST_PRD, ST_PWR) on the buffer's single port pair.
// A waiting result stalls only the next pixel read.
`default_nettype none
module quad_scanline_zbuffer_rasterizer #(
  parameter int FRAME_WIDTH  = qsz_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = qsz_pkg::FRAME_HEIGHT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_op,
  input  wire logic [1:0]         in_corner,
  input  wire logic signed [15:0] in_vert_x,
  input  wire logic signed [15:0] in_vert_y,
  input  wire logic signed [15:0] in_vert_z,
  input  wire logic [2:0]         in_face_id,
  input  wire logic [9:0]         in_read_col,
  input  wire logic [9:0]         in_read_row,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_pixel_depth,
  output logic [2:0]              out_pixel_face
);

  localparam int PIX    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW     = $clog2(PIX);
  localparam int ROW_W  = $clog2(FRAME_HEIGHT + 1);
  localparam int HALF_W = FRAME_WIDTH / 2;
  localparam int HALF_H = FRAME_HEIGHT / 2;
  localparam int CRD_W  = qsz_pkg::CRD_W;
  localparam int MUL_W  = qsz_pkg::MUL_W;
  localparam int PROD_W = qsz_pkg::PROD_W;
  localparam int DEN_W  = qsz_pkg::DEN_W;

  qsz_pkg::state_t state_r, state_nxt;

  logic signed [15:0] cx_r [4], cy_r [4], cz_r [4];
  logic signed [15:0] cx_nxt [4], cy_nxt [4], cz_nxt [4];
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [1:0]         edge_r, edge_nxt, hits_r, hits_nxt;
  qsz_pkg::crd_t      bx_r, bz_r, ex_r, ez_r, hx_r, hz_r, i_r, stop_r, col_r;
  qsz_pkg::crd_t      bx_nxt, bz_nxt, ex_nxt, ez_nxt, hx_nxt, hz_nxt, i_nxt, stop_nxt, col_nxt;
  logic               hit_r, hit_nxt, phase_r, phase_nxt, span_r, span_nxt;
  logic               oob_r, oob_nxt;
  logic signed [15:0] z_r, z_nxt;
  logic [2:0]         face_r, face_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [DEN_W-1:0]  den_r, den_nxt;
  logic [AW-1:0]      addr_r, addr_nxt, clr_r, clr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_depth_r, out_depth_nxt;
  logic [2:0]         out_face_r, out_face_nxt;

  logic                     fb_we;
  logic [AW-1:0]            fb_waddr;
  logic [qsz_pkg::ENT_W-1:0] fb_wdata, fb_rdata;
  logic                     div_start, div_busy, div_done;
  logic signed [PROD_W-1:0] div_quo;

  // edge operands, P is corner slot 0 and Q slot 1 (slots rotate per edge)
  qsz_pkg::crd_t      y_s, px, py, pz, qx, qy, qz, dp, dq, cnd, top16, itmp;
  logic signed [PROD_W:0] zfull;
  logic signed [15:0] rd_depth;
  logic               in_acc, next_row;

  always_comb begin
    px = CRD_W'(cx_r[0]);
    py = CRD_W'(cy_r[0]);
    pz = CRD_W'(cz_r[0]);
    qx = CRD_W'(cx_r[1]);
    qy = CRD_W'(cy_r[1]);
    qz = CRD_W'(cz_r[1]);
    y_s = (CRD_W'(row_r) - CRD_W'(HALF_H)) <<< 4;
    dp = y_s - py;
    dq = y_s - qy;
    rd_depth = fb_rdata[qsz_pkg::ENT_W-1:3];
  end

  always_comb begin
    state_nxt = state_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    cz_nxt = cz_r;
    row_nxt = row_r;
    edge_nxt = edge_r;
    hits_nxt = hits_r;
    bx_nxt = bx_r;
    bz_nxt = bz_r;
    ex_nxt = ex_r;
    ez_nxt = ez_r;
    hx_nxt = hx_r;
    hz_nxt = hz_r;
    i_nxt = i_r;
    stop_nxt = stop_r;
    col_nxt = col_r;
    hit_nxt = hit_r;
    phase_nxt = phase_r;
    span_nxt = span_r;
    oob_nxt = oob_r;
    z_nxt = z_r;
    face_nxt = face_r;
    prod_nxt = prod_r;
    den_nxt = den_r;
    addr_nxt = addr_r;
    clr_nxt = clr_r;
    out_valid_nxt = out_valid_r;
    out_depth_nxt = out_depth_r;
    out_face_nxt = out_face_r;
    fb_we = 1'b0;
    fb_waddr = addr_r;
    fb_wdata = {z_r, face_r};
    div_start = 1'b0;
    next_row = 1'b0;
    cnd = '0;
    top16 = '0;
    itmp = '0;
    zfull = '0;
    in_ready = (state_r == qsz_pkg::ST_IDLE);
    in_acc = in_valid && in_ready;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      qsz_pkg::ST_CLEAR: begin
        fb_we = 1'b1;
        fb_waddr = clr_r;
        fb_wdata = {qsz_pkg::DEPTH_EMPTY, 3'd0};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(PIX - 1)) begin
          state_nxt = qsz_pkg::ST_IDLE;
        end
      end
      qsz_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (qsz_pkg::op_t'(in_op))
            qsz_pkg::OP_LOAD: begin
              cx_nxt[in_corner] = in_vert_x;
              cy_nxt[in_corner] = in_vert_y;
              cz_nxt[in_corner] = in_vert_z;
            end
            qsz_pkg::OP_RAST: begin
              row_nxt = '0;
              edge_nxt = '0;
              hits_nxt = '0;
              face_nxt = in_face_id;
              state_nxt = qsz_pkg::ST_EDGE;
            end
            qsz_pkg::OP_CLEAR: begin
              clr_nxt = '0;
              state_nxt = qsz_pkg::ST_CLEAR;
            end
            qsz_pkg::OP_READ: begin
              oob_nxt = !((32'(in_read_col) < 32'(FRAME_WIDTH)) &&
                          (32'(in_read_row) < 32'(FRAME_HEIGHT)));
              addr_nxt = AW'(in_read_row) * AW'(FRAME_WIDTH) + AW'(in_read_col);
              state_nxt = qsz_pkg::ST_RDREQ;
            end
            default: ;
          endcase
        end
      end
      qsz_pkg::ST_RDREQ: state_nxt = qsz_pkg::ST_RDWAIT;
      qsz_pkg::ST_RDWAIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_depth_nxt = oob_r ? qsz_pkg::DEPTH_EMPTY : rd_depth;
          out_face_nxt = oob_r ? 3'd0 : fb_rdata[2:0];
          state_nxt = qsz_pkg::ST_IDLE;
        end
      end
      qsz_pkg::ST_EDGE: begin
        hit_nxt = 1'b0;
        span_nxt = 1'b0;
        if (py == qy && y_s == py) begin
          hx_nxt = (px < qx) ? px : qx;
          hz_nxt = (px < qx) ? pz : qz;
          hit_nxt = 1'b1;
          state_nxt = qsz_pkg::ST_HIT;
        end else if ((dp < 0 && dq > 0) || (dp > 0 && dq < 0)) begin
          phase_nxt = 1'b0;
          state_nxt = qsz_pkg::ST_MUL;
        end else begin
          state_nxt = qsz_pkg::ST_HIT;
        end
      end
      qsz_pkg::ST_MUL: begin
        if (span_r) begin
          prod_nxt = MUL_W'(bz_r - ez_r) * ((MUL_W'(i_r) <<< 4) - MUL_W'(ex_r));
          den_nxt = DEN_W'(bx_r) - DEN_W'(ex_r);
        end else begin
          prod_nxt = MUL_W'(dq) * (phase_r ? MUL_W'(qz - pz) : MUL_W'(qx - px));
          den_nxt = DEN_W'(qy - py);
        end
        state_nxt = qsz_pkg::ST_DSTART;
      end
      qsz_pkg::ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = qsz_pkg::ST_DWAIT;
      end
      qsz_pkg::ST_DWAIT: begin
        if (div_done) begin
          if (span_r) begin
            zfull = (PROD_W+1)'(ez_r) + (PROD_W+1)'(div_quo);
            if (zfull > 32767) begin
              z_nxt = 16'sh7fff;
            end else if (zfull < -32768) begin
              z_nxt = qsz_pkg::DEPTH_EMPTY;
            end else begin
              z_nxt = zfull[15:0];
            end
            state_nxt = qsz_pkg::ST_PADDR;
          end else if (!phase_r) begin
            hx_nxt = qx + CRD_W'(div_quo);
            phase_nxt = 1'b1;
            state_nxt = qsz_pkg::ST_MUL;
          end else begin
            hz_nxt = qz + CRD_W'(div_quo);
            hit_nxt = 1'b1;
            state_nxt = qsz_pkg::ST_HIT;
          end
        end
      end
      qsz_pkg::ST_HIT: begin
        if (hit_r) begin
          if (hits_r == 2'd0) begin
            bx_nxt = hx_r;
            bz_nxt = hz_r;
            hits_nxt = 2'd1;
          end else if (hits_r == 2'd1 && hx_r != bx_r) begin
            hits_nxt = 2'd2;
            if (hx_r < bx_r) begin
              ex_nxt = bx_r;
              ez_nxt = bz_r;
              bx_nxt = hx_r;
              bz_nxt = hz_r;
            end else begin
              ex_nxt = hx_r;
              ez_nxt = hz_r;
            end
          end
        end
        for (int k = 0; k < 4; k++) begin
          cx_nxt[k] = cx_r[(k + 1) % 4];
          cy_nxt[k] = cy_r[(k + 1) % 4];
          cz_nxt[k] = cz_r[(k + 1) % 4];
        end
        edge_nxt = edge_r + 1'b1;
        state_nxt = (edge_r == 2'd3) ? qsz_pkg::ST_ROWEND : qsz_pkg::ST_EDGE;
      end
      qsz_pkg::ST_ROWEND: begin
        if (hits_r == 2'd1) begin
          cnd = qsz_pkg::trunc16(bx_r + CRD_W'(16 * HALF_W));
          col_nxt = cnd;
          z_nxt = bz_r[15:0];
          span_nxt = 1'b0;
          if (cnd >= 0 && cnd < CRD_W'(FRAME_WIDTH)) begin
            state_nxt = qsz_pkg::ST_PADDR;
          end else begin
            next_row = 1'b1;
          end
        end else if (hits_r == 2'd2) begin
          itmp = qsz_pkg::trunc16(bx_r);
          if (itmp < -CRD_W'(HALF_W)) itmp = -CRD_W'(HALF_W);
          top16 = qsz_pkg::trunc16(ex_r);
          if (top16 > CRD_W'(FRAME_WIDTH - HALF_W)) top16 = CRD_W'(FRAME_WIDTH - HALF_W);
          i_nxt = itmp;
          stop_nxt = top16;
          span_nxt = 1'b1;
          if (itmp < top16) begin
            state_nxt = qsz_pkg::ST_SPAN;
          end else begin
            next_row = 1'b1;
          end
        end else begin
          next_row = 1'b1;
        end
      end
      qsz_pkg::ST_SPAN: begin
        col_nxt = i_r + CRD_W'(HALF_W);
        if (bz_r == ez_r) begin
          z_nxt = bz_r[15:0];
          state_nxt = qsz_pkg::ST_PADDR;
        end else begin
          state_nxt = qsz_pkg::ST_MUL;
        end
      end
      qsz_pkg::ST_PADDR: begin
        addr_nxt = AW'(row_r) * AW'(FRAME_WIDTH) + AW'(col_r);
        state_nxt = qsz_pkg::ST_PRD;
      end
      qsz_pkg::ST_PRD: state_nxt = qsz_pkg::ST_PWR;
      qsz_pkg::ST_PWR: begin
        fb_we = (z_r > rd_depth);
        if (span_r && (i_r + qsz_pkg::crd_t'(1)) < stop_r) begin
          i_nxt = i_r + qsz_pkg::crd_t'(1);
          state_nxt = qsz_pkg::ST_SPAN;
        end else begin
          next_row = 1'b1;
        end
      end
      default: state_nxt = qsz_pkg::ST_IDLE;
    endcase

    if (next_row) begin
      hits_nxt = '0;
      edge_nxt = '0;
      row_nxt = row_r + 1'b1;
      state_nxt = (row_r == ROW_W'(FRAME_HEIGHT - 1)) ? qsz_pkg::ST_IDLE : qsz_pkg::ST_EDGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qsz_pkg::ST_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      hits_r <= '0;
      edge_r <= '0;
      row_r <= '0;
      for (int k = 0; k < 4; k++) begin
        cx_r[k] <= '0;
        cy_r[k] <= '0;
        cz_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      hits_r <= hits_nxt;
      edge_r <= edge_nxt;
      row_r <= row_nxt;
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cz_r <= cz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bx_r <= bx_nxt;
    bz_r <= bz_nxt;
    ex_r <= ex_nxt;
    ez_r <= ez_nxt;
    hx_r <= hx_nxt;
    hz_r <= hz_nxt;
    i_r <= i_nxt;
    stop_r <= stop_nxt;
    col_r <= col_nxt;
    hit_r <= hit_nxt;
    phase_r <= phase_nxt;
    span_r <= span_nxt;
    oob_r <= oob_nxt;
    z_r <= z_nxt;
    face_r <= face_nxt;
    prod_r <= prod_nxt;
    den_r <= den_nxt;
    addr_r <= addr_nxt;
    out_depth_r <= out_depth_nxt;
    out_face_r <= out_face_nxt;
  end

  qsz_div #(
    .NW (PROD_W),
    .DW (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (den_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  qsz_fbuf #(
    .DEPTH (PIX),
    .AW    (AW)
  ) u_fbuf (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .raddr (addr_r),
    .rdata (fb_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_pixel_depth = out_depth_r;
  assign out_pixel_face  = out_face_r;

  a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qsz_pkg::ST_RDREQ || state_r == qsz_pkg::ST_RDWAIT) |-> !fb_we)
    else $error("buffer written during pixel read");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_busy)
    else $error("divider running while idle");

  a_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hits_r != 2'd3)
    else $error("more than two row hits");

  a_depth_test: assert property (@(posedge clk) disable iff (!rst_n)
    (fb_we && state_r == qsz_pkg::ST_PWR) |-> (z_r > rd_depth))
    else $error("pixel write failed depth test");

endmodule
`default_nettype wire
